// ----- rtl/rat_pkg.sv -----
// ----------------------------------------------------------------------------
// rat_pkg: region address translation table shared types
// Opcodes, status codes, region kinds and the request/response structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rat_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned HitW  = 6;
  localparam int unsigned KindW = 3;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_V2R  = 3'd1,
    OP_R2V  = 3'd2,
    OP_WCHK = 3'd3,
    OP_DEL  = 3'd4
  } rat_op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNMAPPED = 3'd1,
    ST_DENIED   = 3'd2,
    ST_SECTION  = 3'd3,
    ST_FULL     = 3'd4
  } rat_status_e;

  localparam logic [KindW-1:0] KIND_READONLY = 3'd1;
  localparam logic [KindW-1:0] KIND_LIBRARY  = 3'd2;
  localparam logic [KindW-1:0] KIND_PROGRAM  = 3'd3;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] real_base;
    logic [AddrW-1:0] virtual_base;
    logic [AddrW-1:0] region_size;
    logic [KindW-1:0] region_kind;
  } rat_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] translated;
    logic [HitW-1:0]  hit_entry;
  } rat_rsp_t;

  // Request as it travels down the cell row, with the search outcome so far.
  typedef struct packed {
    rat_req_t         req;
    logic             full;
    logic             found;
    logic [AddrW-1:0] offset;
    logic [AddrW-1:0] base_to;
    logic [KindW-1:0] hit_kind;
  } rat_flow_t;

endpackage

`default_nettype wire

// ----- rtl/rat_cell.sv -----
// ----------------------------------------------------------------------------
// rat_cell: one table entry of the region translation row
// Holds one region, matches the passing request and hands it on a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rat_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned IdxW = 6,
  parameter int unsigned CntW = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire logic                vld_i,
  input  wire rat_pkg::rat_flow_t  flow_i,
  input  wire logic [CntW-1:0]     cnt_i,
  input  wire logic [IdxW-1:0]     hit_i,
  output      logic                vld_o,
  output      rat_pkg::rat_flow_t  flow_o,
  output      logic [CntW-1:0]     cnt_o,
  output      logic [IdxW-1:0]     hit_o
);

  logic [rat_pkg::AddrW-1:0] rb_q, vb_q, sz_q;
  logic [rat_pkg::KindW-1:0] kd_q;

  logic                      vld_q;
  rat_pkg::rat_flow_t        flow_q, flow_d;
  logic [CntW-1:0]           cnt_q;
  logic [IdxW-1:0]           hit_q, hit_d;

  logic                      by_real, incl, search, live, in_rng, hit, wr_add;
  logic [rat_pkg::AddrW-1:0] key, dest;
  logic [rat_pkg::AddrW:0]   diff, span;

  always_comb begin
    by_real = (flow_i.req.opcode == rat_pkg::OP_R2V);
    incl    = (flow_i.req.opcode == rat_pkg::OP_DEL);
    search  = (flow_i.req.opcode == rat_pkg::OP_V2R) || (flow_i.req.opcode == rat_pkg::OP_R2V)
           || (flow_i.req.opcode == rat_pkg::OP_WCHK) || (flow_i.req.opcode == rat_pkg::OP_DEL);
    key     = by_real ? rb_q : vb_q;
    dest    = by_real ? vb_q : rb_q;
    // borrow in diff: address below base; carry in span: region end wraps
    diff    = {1'b0, flow_i.req.address} - {1'b0, key};
    span    = {1'b0, key} + {1'b0, sz_q};
    in_rng  = !diff[rat_pkg::AddrW] && !span[rat_pkg::AddrW] && (sz_q != '0)
           && (incl ? (diff[rat_pkg::AddrW-1:0] <= sz_q) : (diff[rat_pkg::AddrW-1:0] < sz_q));
    live    = (CntW'(Idx) < cnt_i);
    hit     = vld_i && live && search && !flow_i.found && in_rng;
    wr_add  = vld_i && (flow_i.req.opcode == rat_pkg::OP_ADD) && !flow_i.full
           && (cnt_i == CntW'(Idx));

    flow_d = flow_i;
    hit_d  = hit_i;
    if (hit) begin
      flow_d.found    = 1'b1;
      flow_d.offset   = diff[rat_pkg::AddrW-1:0];
      flow_d.base_to  = dest;
      flow_d.hit_kind = kd_q;
      hit_d           = IdxW'(Idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      flow_q <= flow_d;
      cnt_q  <= cnt_i;
      hit_q  <= hit_d;
    end
  end

  // Region store: written by an add, size cleared by a delete hit.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (wr_add) begin
        rb_q <= flow_i.req.real_base;
        vb_q <= flow_i.req.virtual_base;
        sz_q <= flow_i.req.region_size;
        kd_q <= flow_i.req.region_kind;
      end else if (hit && incl) begin
        sz_q <= '0;
      end
    end
  end

  assign vld_o  = vld_q;
  assign flow_o = flow_q;
  assign cnt_o  = cnt_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire

// ----- rtl/rat_result.sv -----
// ----------------------------------------------------------------------------
// rat_result: response stage of the region translation table
// Turns the search outcome into status, translated address and entry index.
// ----------------------------------------------------------------------------
`default_nettype none

module rat_result #(
  parameter int unsigned IdxW = 6,
  parameter int unsigned CntW = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                vld_i,
  input  wire rat_pkg::rat_flow_t  flow_i,
  input  wire logic [CntW-1:0]     cnt_i,
  input  wire logic [IdxW-1:0]     hit_i,
  output      logic                adv_o,
  output      logic                rsp_valid_o,
  input  wire logic                rsp_ready_i,
  output      rat_pkg::rat_rsp_t   rsp_o
);

  logic                      vld_q;
  rat_pkg::rat_rsp_t         rsp_q, rsp_d;
  logic [rat_pkg::AddrW-1:0] xlat;

  assign xlat  = flow_i.offset + flow_i.base_to;
  assign adv_o = !vld_q || rsp_ready_i;

  always_comb begin
    rsp_d.status     = rat_pkg::ST_UNMAPPED;
    rsp_d.translated = '0;
    rsp_d.hit_entry  = '0;
    unique case (flow_i.req.opcode)
      rat_pkg::OP_ADD: begin
        if (flow_i.full) begin
          rsp_d.status = rat_pkg::ST_FULL;
        end else begin
          rsp_d.status    = rat_pkg::ST_OK;
          rsp_d.hit_entry = rat_pkg::HitW'(cnt_i);
        end
      end
      rat_pkg::OP_V2R, rat_pkg::OP_R2V, rat_pkg::OP_WCHK: begin
        if (flow_i.found) begin
          rsp_d.status     = rat_pkg::ST_OK;
          rsp_d.translated = xlat;
          rsp_d.hit_entry  = rat_pkg::HitW'(hit_i);
          if (flow_i.req.opcode == rat_pkg::OP_WCHK) begin
            if (flow_i.hit_kind == rat_pkg::KIND_READONLY
                || flow_i.hit_kind == rat_pkg::KIND_LIBRARY) begin
              rsp_d.status = rat_pkg::ST_DENIED;
            end else if (flow_i.hit_kind == rat_pkg::KIND_PROGRAM) begin
              rsp_d.status = rat_pkg::ST_SECTION;
            end
          end
        end
      end
      rat_pkg::OP_DEL: begin
        if (flow_i.found) begin
          rsp_d.status    = rat_pkg::ST_OK;
          rsp_d.hit_entry = rat_pkg::HitW'(hit_i);
        end
      end
      default: begin
        rsp_d.status = rat_pkg::ST_UNMAPPED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = vld_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/region_address_translation_table.sv -----
// ----------------------------------------------------------------------------
// region_address_translation_table: region based address translation table
// Add, translate both ways, write check and delete over a row of region cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  request | in        | req_valid_i/req_ready_o | req_i  (rat_pkg::rat_req_t)
//  response| out       | rsp_valid_o/rsp_ready_i | rsp_o  (rat_pkg::rat_rsp_t)
//
//  A request walks the row of ENTRIES cells, one register stage per cell,
//    then passes the response register.
//  The row is a systolic pipeline, so one request may enter every cycle
//    unless the response stalls; each cell sees requests in arrival order,
//    so adds and deletes apply to later requests exactly as in a serial table.
//  Reset clears the fill count and all stage valids; region stores are not
//    cleared, entries at or above the count carried by a request never match.
//  A stalled response freezes the whole row and drops req_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module region_address_translation_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output      logic               req_ready_o,
  input  wire rat_pkg::rat_req_t  req_i,
  output      logic               rsp_valid_o,
  input  wire logic               rsp_ready_i,
  output      rat_pkg::rat_rsp_t  rsp_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  // Link k feeds cell k-1; link ENTRIES is the entry point, link 0 the tail.
  logic               link_vld  [ENTRIES+1];
  rat_pkg::rat_flow_t link_flow [ENTRIES+1];
  logic [CntW-1:0]    link_cnt  [ENTRIES+1];
  logic [IdxW-1:0]    link_hit  [ENTRIES+1];

  logic               adv;
  logic               req_acc;
  logic               full;
  logic [CntW-1:0]    entry_cnt_q, entry_cnt_d;

  assign req_ready_o = adv;
  assign req_acc     = req_valid_i && req_ready_o;
  assign full        = (entry_cnt_q >= CntW'(ENTRIES));

  // Fill count: an add claims the next slot at acceptance; slots never return.
  always_comb begin
    entry_cnt_d = entry_cnt_q;
    if (req_acc && (req_i.opcode == rat_pkg::OP_ADD) && !full) begin
      entry_cnt_d = entry_cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q <= '0;
    end else begin
      entry_cnt_q <= entry_cnt_d;
    end
  end

  // Request enters at the newest cell with the count as seen on acceptance.
  always_comb begin
    link_vld[ENTRIES]           = req_valid_i;
    link_flow[ENTRIES].req      = req_i;
    link_flow[ENTRIES].full     = full;
    link_flow[ENTRIES].found    = 1'b0;
    link_flow[ENTRIES].offset   = '0;
    link_flow[ENTRIES].base_to  = '0;
    link_flow[ENTRIES].hit_kind = '0;
    link_cnt[ENTRIES]           = entry_cnt_q;
    link_hit[ENTRIES]           = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rat_cell #(
      .Idx  (g),
      .IdxW (IdxW),
      .CntW (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (link_vld[g+1]),
      .flow_i (link_flow[g+1]),
      .cnt_i  (link_cnt[g+1]),
      .hit_i  (link_hit[g+1]),
      .vld_o  (link_vld[g]),
      .flow_o (link_flow[g]),
      .cnt_o  (link_cnt[g]),
      .hit_o  (link_hit[g])
    );
  end

  rat_result #(
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (link_vld[0]),
    .flow_i      (link_flow[0]),
    .cnt_i       (link_cnt[0]),
    .hit_i       (link_hit[0]),
    .adv_o       (adv),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  // Checks

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_cnt_q <= CntW'(ENTRIES))
    else $error("fill count beyond table size");

  a_cnt_add : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_i.opcode == rat_pkg::OP_ADD) && !full)
    |=> (entry_cnt_q == $past(entry_cnt_q) + CntW'(1)))
    else $error("accepted add did not claim a slot");

  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_o |-> req_ready_o)
    else $error("row stalled with no pending response");

  a_full_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == rat_pkg::ST_FULL)) |-> full)
    else $error("table full reported below capacity");

endmodule

`default_nettype wire
